[rtl/core/cascaded_biquad_equalizer_assert.svh]
// Assertion macros for the equalizer's checker file.
// Needs nothing else; the caller supplies clock, reset and message.
`ifndef CASCADED_BIQUAD_EQUALIZER_ASSERT_SVH
`define CASCADED_BIQUAD_EQUALIZER_ASSERT_SVH

// same-cycle implication, reset masks the check
`define BEQ_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BEQ_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/beq_pkg.sv]
// Shared constants, codes and types of the cascaded biquad equaliser.
// No dependencies; every other file but the assertion header imports this package.
package beq_pkg;

	localparam int MAX_BANDS = 16;
	localparam int CHANNELS  = 2;

	localparam int NCOEF = 5;
	localparam int HIST  = 4;

	localparam int SAMPLE_W = 24;
	localparam int DATA_W   = 32;
	localparam int CMD_W    = 2;
	localparam int BAND_W   = 4;
	localparam int SEL_W    = 3;
	localparam int ACTB_W   = 5;
	localparam int PADDR_W  = 3;
	localparam int REG_W    = PADDR_W - 2;

	localparam int PROD_W = 2 * DATA_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int FRAC_C = 28;

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int BIDX_W = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
	localparam int BCNT_W = $clog2(MAX_BANDS + 1);
	localparam int HIDX_W = $clog2(HIST);
	localparam int STEP_W = $clog2(NCOEF + 1);

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NCOEF);

	// half an LSB of the Q8.24 result, preloaded into the accumulator
	localparam logic signed [ACC_W-1:0] ACC_RND =
		{{(ACC_W - FRAC_C){1'b0}}, 1'b1, {(FRAC_C - 1){1'b0}}};

	typedef enum logic [CMD_W-1:0] {
		CMD_FILTER = 2'd0,
		CMD_COEF   = 2'd1,
		CMD_CLEAR  = 2'd2
	} beq_cmd_t;

	localparam logic [SEL_W-1:0] COEF_B0 = 3'd0;
	localparam logic [SEL_W-1:0] COEF_B1 = 3'd1;
	localparam logic [SEL_W-1:0] COEF_B2 = 3'd2;
	localparam logic [SEL_W-1:0] COEF_A1 = 3'd3;
	localparam logic [SEL_W-1:0] COEF_A2 = 3'd4;

	localparam logic [HIDX_W-1:0] H_X1 = 2'd0;
	localparam logic [HIDX_W-1:0] H_X2 = 2'd1;
	localparam logic [HIDX_W-1:0] H_Y1 = 2'd2;
	localparam logic [HIDX_W-1:0] H_Y2 = 2'd3;

	typedef struct packed {
		logic                     clear;
		logic                     we;
		logic [SEL_W-1:0]         sel;
		logic signed [DATA_W-1:0] data;
		logic                     ch;
	} beq_cell_ctl_t;

endpackage

[rtl/core/beq_if.sv]
// Valid/ready stream interfaces of the equaliser: sample beats in, results out.
// Depends on beq_pkg for field widths.
interface beq_in_if;
	import beq_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [CMD_W-1:0]           command;
	logic                       channel;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic [BAND_W-1:0]          band_index;
	logic [SEL_W-1:0]           coeff_select;
	logic signed [DATA_W-1:0]   coeff_value;

	modport source (
		output valid, command, channel, sample_in, band_index, coeff_select, coeff_value,
		input  ready
	);
	modport sink (
		input  valid, command, channel, sample_in, band_index, coeff_select, coeff_value,
		output ready
	);
endinterface

interface beq_out_if;
	import beq_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       channel_out;
	logic signed [SAMPLE_W-1:0] sample_out;

	modport source (
		output valid, channel_out, sample_out,
		input  ready
	);
	modport sink (
		input  valid, channel_out, sample_out,
		output ready
	);
endinterface

[rtl/core/beq_cell.sv]
// One biquad section of the cascade: coefficients, per-channel history and a MAC.
// Depends on beq_pkg. Takes x on go, hands y to the next cell with done.
module beq_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  beq_pkg::beq_cell_ctl_t           ctl,
	input  logic                             go,
	input  logic signed [beq_pkg::DATA_W-1:0] x_in,
	output logic                             done,
	output logic signed [beq_pkg::DATA_W-1:0] y_out
);
	import beq_pkg::*;

	localparam int SH_W = ACC_W - FRAC_C;

	logic signed [DATA_W-1:0] coef_q [NCOEF];
	logic signed [DATA_W-1:0] hist_q [CHANNELS][HIST];

	logic                     busy_q;
	logic [STEP_W-1:0]        step_q;
	logic                     done_q;
	logic signed [DATA_W-1:0] x_q;
	logic signed [DATA_W-1:0] y_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic                     neg_s1;

	logic [CH_W-1:0]          ch;
	logic signed [DATA_W-1:0] mul_a;
	logic signed [DATA_W-1:0] mul_b;
	logic signed [ACC_W-1:0]  addend;
	logic signed [ACC_W-1:0]  acc_sum;
	logic [SH_W-1:0]          sh;
	logic signed [DATA_W-1:0] y_new;
	logic                     last;

	assign ch   = CH_W'(ctl.ch);
	assign last = busy_q && (step_q == STEP_LAST);

	// b0*x on the go cycle, then x1, x2, y1, y2 one per cycle
	always_comb begin
		mul_a = coef_q[COEF_B0];
		mul_b = x_in;
		if (busy_q) begin
			case (step_q)
				COEF_B1: begin
					mul_a = coef_q[COEF_B1];
					mul_b = hist_q[ch][H_X1];
				end
				COEF_B2: begin
					mul_a = coef_q[COEF_B2];
					mul_b = hist_q[ch][H_X2];
				end
				COEF_A1: begin
					mul_a = coef_q[COEF_A1];
					mul_b = hist_q[ch][H_Y1];
				end
				COEF_A2: begin
					mul_a = coef_q[COEF_A2];
					mul_b = hist_q[ch][H_Y2];
				end
				default: begin
					mul_a = coef_q[COEF_B0];
					mul_b = x_q;
				end
			endcase
		end
	end

	assign addend  = neg_s1 ? -ACC_W'(prod_s1) : ACC_W'(prod_s1);
	assign acc_sum = acc_q + addend;
	assign sh      = acc_sum[ACC_W-1:FRAC_C];

	always_comb begin
		if (&sh[SH_W-1:DATA_W-1] || ~|sh[SH_W-1:DATA_W-1]) begin
			y_new = sh[DATA_W-1:0];
		end else if (sh[SH_W-1]) begin
			y_new = {1'b1, {(DATA_W - 1){1'b0}}};
		end else begin
			y_new = {1'b0, {(DATA_W - 1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (go) begin
					busy_q <= 1'b1;
					step_q <= STEP_W'(COEF_B1);
				end
			end else if (last) begin
				busy_q <= 1'b0;
				step_q <= '0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && go) begin
			x_q   <= x_in;
			acc_q <= ACC_RND;
		end else if (busy_q) begin
			acc_q <= acc_sum;
		end
		prod_s1 <= mul_a * mul_b;
		neg_s1  <= busy_q && (step_q == COEF_A1 || step_q == COEF_A2);
		if (last) begin
			y_q <= y_new;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			coef_q[ctl.sel] <= ctl.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '{default: '0};
		end else if (ctl.clear) begin
			hist_q <= '{default: '0};
		end else if (last) begin
			hist_q[ch][H_X2] <= hist_q[ch][H_X1];
			hist_q[ch][H_X1] <= x_q;
			hist_q[ch][H_Y2] <= hist_q[ch][H_Y1];
			hist_q[ch][H_Y1] <= y_new;
		end
	end

	assign done  = done_q;
	assign y_out = y_q;

endmodule

[rtl/core/cascaded_biquad_equalizer.sv]
// Top level of the multichannel cascaded biquad equaliser.
// Depends on beq_pkg, beq_in_if, beq_out_if and beq_cell.
//
//  port      dir  kind         carries
//  sample    in   valid/ready  command, channel, sample_in, band_index,
//                              coeff_select, coeff_value
//  result    out  valid/ready  channel_out, sample_out
//  apb       in   psel/penable preamp_gain at 0x0, active_bands at 0x4
//
// A sample beat holds the block through accept, preamp multiply, preamp rounding,
// the active sections (capped at MAX_BANDS; per section five products plus the
// multiplier register) and handover. Other beats leave the block idle.
// Reset zeroes history and band count, sets unity gain; coefficients undefined.
// Results sit in an output register, so a stalled result only holds the block
// when the next sample finishes before it has been taken.
module cascaded_biquad_equalizer (
	input  logic                         clk,
	input  logic                         arst_n,
	beq_in_if.sink                       sample,
	beq_out_if.source                    result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [beq_pkg::PADDR_W-1:0]  paddr,
	input  logic [beq_pkg::DATA_W-1:0]   pwdata,
	output logic [beq_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);
	import beq_pkg::*;

	localparam int PRE_W  = SAMPLE_W + DATA_W;
	localparam int PRE_SH = 27;

	localparam logic [REG_W-1:0] REG_PREAMP = 1'b0;
	localparam logic [REG_W-1:0] REG_BANDS  = 1'b1;

	localparam logic signed [PRE_W:0] PRE_RND = (PRE_W + 1)'(1) << (PRE_SH - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE,
		ST_RND,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t                     state_q;
	logic                       out_valid_q;
	logic                       out_ch_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;

	logic signed [DATA_W-1:0]   preamp_q;
	logic [ACTB_W-1:0]          bands_q;

	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       ch_q;
	logic signed [PRE_W-1:0]    prod_s1;
	logic signed [DATA_W-1:0]   y_fin_q;

	logic                       in_acc;
	logic                       filt_ok;
	logic                       coef_wr;
	logic                       clr;
	logic [REG_W-1:0]           reg_idx;
	logic [BCNT_W-1:0]          nb_w;
	logic [BIDX_W-1:0]          last_idx;
	logic                       chain_done;
	logic signed [DATA_W-1:0]   y_last;
	logic signed [PRE_W:0]      pre_sum;
	logic signed [DATA_W-1:0]   pre_y;
	logic signed [DATA_W:0]     out_sum;
	logic signed [DATA_W-1:0]   out_half;
	logic signed [SAMPLE_W-1:0] out_w;

	beq_cell_ctl_t              cell_ctl  [MAX_BANDS];
	logic [MAX_BANDS-1:0]       cell_go;
	logic [MAX_BANDS-1:0]       cell_done;
	logic signed [DATA_W-1:0]   cell_x    [MAX_BANDS];
	logic signed [DATA_W-1:0]   cell_y    [MAX_BANDS];

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamp_q <= 32'sh1000_0000;
			bands_q  <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_PREAMP: preamp_q <= pwdata;
				REG_BANDS:  bands_q  <= pwdata[ACTB_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PREAMP: prdata = preamp_q;
			REG_BANDS:  prdata = DATA_W'(bands_q);
			default:    prdata = '0;
		endcase
	end

	// input decode
	assign in_acc  = sample.valid && sample.ready;
	assign filt_ok = (sample.command == CMD_FILTER) && (int'(sample.channel) < CHANNELS);
	assign coef_wr = in_acc && (sample.command == CMD_COEF)
		&& (int'(sample.band_index) < MAX_BANDS) && (int'(sample.coeff_select) < NCOEF);
	assign clr     = in_acc && (sample.command == CMD_CLEAR);
	assign sample.ready = (state_q == ST_IDLE);

	assign nb_w = (int'(bands_q) > MAX_BANDS) ? BCNT_W'(MAX_BANDS) : BCNT_W'(bands_q);
	assign last_idx   = BIDX_W'(nb_w - 1'b1);
	assign chain_done = cell_done[last_idx];
	assign y_last     = cell_y[last_idx];

	// preamp: |sample * gain| <= 2^54, so the Q8.24 result never overflows
	assign pre_sum = {prod_s1[PRE_W-1], prod_s1} + PRE_RND;
	assign pre_y   = DATA_W'(signed'(pre_sum[PRE_W:PRE_SH]));

	// output: Q8.24 to Q1.23, round half up, saturate
	assign out_sum  = {y_fin_q[DATA_W-1], y_fin_q} + (DATA_W + 1)'(1);
	assign out_half = out_sum[DATA_W:1];

	always_comb begin
		if (&out_half[DATA_W-1:SAMPLE_W-1] || ~|out_half[DATA_W-1:SAMPLE_W-1]) begin
			out_w = out_half[SAMPLE_W-1:0];
		end else if (out_half[DATA_W-1]) begin
			out_w = {1'b1, {(SAMPLE_W - 1){1'b0}}};
		end else begin
			out_w = {1'b0, {(SAMPLE_W - 1){1'b1}}};
		end
	end

	// section cells, each passing its output to the next
	for (genvar i = 0; i < MAX_BANDS; i++) begin : g_band
		assign cell_ctl[i] = '{
			clear: clr,
			we:    coef_wr && (int'(sample.band_index) == i),
			sel:   sample.coeff_select,
			data:  sample.coeff_value,
			ch:    ch_q
		};

		if (i == 0) begin : g_head
			assign cell_go[i] = (state_q == ST_RND) && (nb_w != '0);
			assign cell_x[i]  = pre_y;
		end else begin : g_link
			assign cell_go[i] = cell_done[i-1] && (i < int'(nb_w));
			assign cell_x[i]  = cell_y[i-1];
		end

		beq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (cell_ctl[i]),
			.go     (cell_go[i]),
			.x_in   (cell_x[i]),
			.done   (cell_done[i]),
			.y_out  (cell_y[i])
		);
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= sample.sample_in;
			ch_q     <= sample.channel;
		end
		prod_s1 <= sample_q * preamp_q;
		if (state_q == ST_RND) begin
			y_fin_q <= pre_y;
		end else if (state_q == ST_RUN && chain_done) begin
			y_fin_q <= y_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			out_ch_q     <= 1'b0;
			out_sample_q <= '0;
		end else begin
			if (result.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && filt_ok) begin
						state_q <= ST_PRE;
					end
				end
				ST_PRE: state_q <= ST_RND;
				ST_RND: state_q <= (nb_w == '0) ? ST_DONE : ST_RUN;
				ST_RUN: begin
					if (chain_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q  <= 1'b1;
						out_ch_q     <= ch_q;
						out_sample_q <= out_w;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid       = out_valid_q;
	assign result.channel_out = out_ch_q;
	assign result.sample_out  = out_sample_q;

endmodule

[rtl/core/beq_checker.sv]
// Port-level checks on the equaliser's beat sequencing, bound to the top level.
// Depends on beq_pkg and cascaded_biquad_equalizer_assert.svh.
`include "cascaded_biquad_equalizer_assert.svh"

module beq_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic [beq_pkg::CMD_W-1:0]         in_command,
	input logic                              in_channel,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              out_channel,
	input logic signed [beq_pkg::SAMPLE_W-1:0] out_sample
);
	import beq_pkg::*;

	logic in_acc;
	logic filt_acc;
	logic ctl_acc;
	logic out_stall;

	assign in_acc    = in_valid && in_ready;
	assign filt_acc  = in_acc && (in_command == CMD_FILTER) && (int'(in_channel) < CHANNELS);
	assign ctl_acc   = in_acc && !filt_acc;
	assign out_stall = out_valid && !out_ready;

	// a sample beat leaves the block busy and not ready for another beat
	`BEQ_ASSERT_NXT(a_busy_after_sample, clk, arst_n, filt_acc, !in_ready, "ready after sample beat")

	// writes, clears and dropped beats finish in their own cycle
	`BEQ_ASSERT_NXT(a_idle_after_ctl, clk, arst_n, ctl_acc, in_ready, "busy after control beat")

	// a fresh result only follows a busy cycle
	`BEQ_ASSERT_IMP(a_result_from_work, clk, arst_n, $rose(out_valid), $past(!in_ready), "result from idle")

	`BEQ_ASSERT_NXT(a_result_held, clk, arst_n, out_stall, out_valid && $stable(out_sample) && $stable(out_channel), "stalled result changed")

endmodule

bind cascaded_biquad_equalizer beq_checker u_beq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (sample.valid),
	.in_ready    (sample.ready),
	.in_command  (sample.command),
	.in_channel  (sample.channel),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_channel (result.channel_out),
	.out_sample  (result.sample_out)
);
